### hdl/bls_pkg.sv
// Shared types and constants for the bitplane line stepper.
// No dependencies; every other file in hdl/ imports this package.

package bls_pkg;

    // Kind of an input transaction, carried on the slave-side tuser.
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } command_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_BASE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_STRIDE = 1'b1;

    localparam int BASE_BITS   = 24;
    localparam int STRIDE_BITS = 12;
    localparam int CFG_BITS    = BASE_BITS;

    localparam logic [BASE_BITS-1:0]   BASE_RESET   = 24'd0;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 12'd40;

    // Pixel mask within one 16-bit word; bit 15 is the leftmost pixel.
    localparam int MASK_BITS = 16;
    localparam logic [MASK_BITS-1:0] MASK_LEFT  = 16'h8000;
    localparam logic [MASK_BITS-1:0] MASK_RIGHT = 16'h0001;

    // Control flags of the line in progress.
    typedef struct packed {
        logic busy;
        logic steep;
        logic going_left;
    } line_flags_t;

endpackage

### hdl/bls_setup.sv
// Line setup: swaps the endpoints, finds the deltas and the start pen position.
// Depends on bls_pkg.

module bls_setup #(
    parameter int COORD_BITS = 10,
    parameter int ADDR_BITS  = 24
) (
    input  logic [COORD_BITS-1:0]            x_start,
    input  logic [COORD_BITS-1:0]            y_start,
    input  logic [COORD_BITS-1:0]            x_end,
    input  logic [COORD_BITS-1:0]            y_end,
    input  logic [bls_pkg::BASE_BITS-1:0]    plane_base,
    input  logic [bls_pkg::STRIDE_BITS-1:0]  row_stride,
    output logic [ADDR_BITS-1:0]             pen_address,
    output logic [bls_pkg::MASK_BITS-1:0]    pen_mask,
    output logic signed [COORD_BITS+2:0]     error_term,
    output logic [COORD_BITS+1:0]            minor_twice,
    output logic [COORD_BITS+1:0]            major_twice,
    output logic [COORD_BITS:0]              pixels_left,
    output bls_pkg::line_flags_t             flags
);
    import bls_pkg::*;

    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int COUNT_BITS = COORD_BITS + 1;
    localparam int PROD_BITS  = COORD_BITS + STRIDE_BITS;
    localparam int WIDE_A     = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;
    localparam int WIDE_BITS  = (WIDE_A > BASE_BITS) ? WIDE_A : BASE_BITS;

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [COORD_BITS-1:0] dx, dy, minor_delta, major_delta;
    logic                  left, steep;
    logic [PROD_BITS-1:0]  row_offset;
    logic [COORD_BITS:0]   word_offset;
    logic [WIDE_BITS-1:0]  address_sum;

    always_comb
    begin
        // Order the endpoints so that y rises along the line.
        if (y_start > y_end)
        begin
            xs = x_end;
            ys = y_end;
            xe = x_start;
            ye = y_start;
        end
        else
        begin
            xs = x_start;
            ys = y_start;
            xe = x_end;
            ye = y_end;
        end

        left  = xe < xs;
        dx    = left ? (xs - xe) : (xe - xs);
        dy    = ye - ys;
        steep = dx < dy;

        minor_delta = steep ? dx : dy;
        major_delta = steep ? dy : dx;

        row_offset  = PROD_BITS'(ys) * PROD_BITS'(row_stride);
        word_offset = {(xs >> 4), 1'b0};
        address_sum = WIDE_BITS'(plane_base) + WIDE_BITS'(row_offset)
                    + WIDE_BITS'(word_offset);
        pen_address = address_sum[ADDR_BITS-1:0];
        pen_mask    = MASK_LEFT >> xs[3:0];

        flags.going_left = left;
        if (dy == '0)
        begin
            // A horizontal line draws nothing.
            flags.busy  = 1'b0;
            flags.steep = 1'b0;
            error_term  = '0;
            minor_twice = '0;
            major_twice = '0;
            pixels_left = '0;
        end
        else
        begin
            flags.busy  = 1'b1;
            flags.steep = steep;
            error_term  = ERR_BITS'(0) - ERR_BITS'(major_delta);
            minor_twice = {1'b0, minor_delta, 1'b0};
            major_twice = {1'b0, major_delta, 1'b0};
            // A y-major line stops short of its final row.
            pixels_left = steep ? COUNT_BITS'(dy) : (COUNT_BITS'(dx) + COUNT_BITS'(1));
        end
    end

endmodule

### hdl/bls_step.sv
// One Bresenham step: error update, mask rotation and address advance.
// Depends on bls_pkg.

module bls_step #(
    parameter int COORD_BITS = 10,
    parameter int ADDR_BITS  = 24
) (
    input  logic [ADDR_BITS-1:0]             pen_address,
    input  logic [bls_pkg::MASK_BITS-1:0]    pen_mask,
    input  logic signed [COORD_BITS+2:0]     error_term,
    input  logic [COORD_BITS+1:0]            minor_twice,
    input  logic [COORD_BITS+1:0]            major_twice,
    input  logic [COORD_BITS:0]              pixels_left,
    input  bls_pkg::line_flags_t             flags,
    input  logic [bls_pkg::STRIDE_BITS-1:0]  row_stride,
    output logic [ADDR_BITS-1:0]             pen_address_next,
    output logic [bls_pkg::MASK_BITS-1:0]    pen_mask_next,
    output logic signed [COORD_BITS+2:0]     error_term_next,
    output logic [COORD_BITS:0]              pixels_left_next,
    output bls_pkg::line_flags_t             flags_next
);
    import bls_pkg::*;

    localparam int ERR_BITS = COORD_BITS + 3;

    logic signed [ERR_BITS-1:0] error_sum;
    logic                       take_minor, move_side, move_down, wraps;
    logic [ADDR_BITS-1:0]       side_delta, down_delta;

    always_comb
    begin
        error_sum  = error_term + $signed(ERR_BITS'(minor_twice));
        take_minor = !error_sum[ERR_BITS-1];
        error_term_next = take_minor ? (error_sum - $signed(ERR_BITS'(major_twice)))
                                     : error_sum;

        move_side = flags.steep ? take_minor : 1'b1;
        move_down = flags.steep ? 1'b1 : take_minor;

        wraps         = 1'b0;
        pen_mask_next = pen_mask;
        if (move_side)
        begin
            if (flags.going_left)
            begin
                wraps         = pen_mask[MASK_BITS-1];
                pen_mask_next = wraps ? MASK_RIGHT : (pen_mask << 1);
            end
            else
            begin
                wraps         = pen_mask[0];
                pen_mask_next = wraps ? MASK_LEFT : (pen_mask >> 1);
            end
        end

        // Crossing a word boundary moves the address by one 16-bit word.
        if (wraps)
            side_delta = flags.going_left ? (ADDR_BITS'(0) - ADDR_BITS'(2)) : ADDR_BITS'(2);
        else
            side_delta = '0;
        down_delta = move_down ? ADDR_BITS'(row_stride) : '0;

        pen_address_next = pen_address + side_delta + down_delta;

        pixels_left_next      = pixels_left - (COORD_BITS + 1)'(1);
        flags_next            = flags;
        flags_next.busy       = pixels_left != (COORD_BITS + 1)'(1);
    end

endmodule

### hdl/bitplane_line_stepper.sv
// Top level of the bitplane line stepper: handshake registers, line state, config.
// Depends on bls_pkg, bls_setup and bls_step.
//
//   Channel      Signals                               Direction
//   -----------  ------------------------------------  ---------
//   commands     s_axis_tvalid/tready/tdata/tuser      in
//   pixel writes m_axis_tvalid/tready/tdata/tlast      out
//   config       cfg_we/cfg_index/cfg_data             in
//
// One transaction is taken every cycle when the output side keeps up. A command
// lands in the input register, is worked on from there (line setup with one
// 10x12 multiply for the row offset, or one Bresenham step), and its pixel
// write leaves from the result register. A start command and a step with no
// line in progress produce no output. Reset clears the handshake and the line
// state; the configuration registers take their reset values. When the output
// is stalled, one command waits in the input register and the slave side then
// drops tready.

module bitplane_line_stepper #(
    parameter int COORD_BITS = 10,
    parameter int ADDR_BITS  = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: x_start, y_start, x_end, y_end.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // Fields from bit 0: command.
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: word_address, bit_mask, zero fill.
    output logic [((ADDR_BITS+16+7)/8)*8-1:0]    m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [bls_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bls_pkg::CFG_BITS-1:0]         cfg_data
);
    import bls_pkg::*;

    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int TWICE_BITS = COORD_BITS + 2;
    localparam int COUNT_BITS = COORD_BITS + 1;
    localparam int IN_BITS    = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_BITS   = ((ADDR_BITS+MASK_BITS+7)/8)*8;

    // Configuration.
    logic [BASE_BITS-1:0]   plane_base_reg;
    logic [STRIDE_BITS-1:0] row_stride_reg;

    // Input register.
    logic                   in_valid_reg;
    command_t               in_command_reg;
    logic [IN_BITS-1:0]     in_data_reg;

    // Line state.
    logic [ADDR_BITS-1:0]       pen_address_reg, pen_address_next;
    logic [MASK_BITS-1:0]       pen_mask_reg, pen_mask_next;
    logic signed [ERR_BITS-1:0] error_term_reg, error_term_next;
    logic [TWICE_BITS-1:0]      minor_twice_reg, minor_twice_next;
    logic [TWICE_BITS-1:0]      major_twice_reg, major_twice_next;
    logic [COUNT_BITS-1:0]      pixels_left_reg, pixels_left_next;
    line_flags_t                flags_reg, flags_next;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]   out_address_reg;
    logic [MASK_BITS-1:0]   out_mask_reg;
    logic                   out_last_reg;

    // Setup and step results.
    logic [ADDR_BITS-1:0]       setup_address, step_address;
    logic [MASK_BITS-1:0]       setup_mask, step_mask;
    logic signed [ERR_BITS-1:0] setup_error, step_error;
    logic [TWICE_BITS-1:0]      setup_minor, setup_major;
    logic [COUNT_BITS-1:0]      setup_pixels, step_pixels;
    line_flags_t                setup_flags, step_flags;

    logic fire, emit;

    // The held command is worked on once its result, if any, has a free slot.
    assign fire = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign emit = fire && (in_command_reg == CMD_STEP) && flags_reg.busy;

    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BITS'({out_mask_reg, out_address_reg});
    assign m_axis_tlast  = out_last_reg;

    bls_setup #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_setup (
        .x_start     (in_data_reg[COORD_BITS-1:0]),
        .y_start     (in_data_reg[2*COORD_BITS-1:COORD_BITS]),
        .x_end       (in_data_reg[3*COORD_BITS-1:2*COORD_BITS]),
        .y_end       (in_data_reg[4*COORD_BITS-1:3*COORD_BITS]),
        .plane_base  (plane_base_reg),
        .row_stride  (row_stride_reg),
        .pen_address (setup_address),
        .pen_mask    (setup_mask),
        .error_term  (setup_error),
        .minor_twice (setup_minor),
        .major_twice (setup_major),
        .pixels_left (setup_pixels),
        .flags       (setup_flags)
    );

    bls_step #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_step (
        .pen_address      (pen_address_reg),
        .pen_mask         (pen_mask_reg),
        .error_term       (error_term_reg),
        .minor_twice      (minor_twice_reg),
        .major_twice      (major_twice_reg),
        .pixels_left      (pixels_left_reg),
        .flags            (flags_reg),
        .row_stride       (row_stride_reg),
        .pen_address_next (step_address),
        .pen_mask_next    (step_mask),
        .error_term_next  (step_error),
        .pixels_left_next (step_pixels),
        .flags_next       (step_flags)
    );

    // Next line state: a start replaces the line, a step advances it.
    always_comb
    begin
        pen_address_next = pen_address_reg;
        pen_mask_next    = pen_mask_reg;
        error_term_next  = error_term_reg;
        minor_twice_next = minor_twice_reg;
        major_twice_next = major_twice_reg;
        pixels_left_next = pixels_left_reg;
        flags_next       = flags_reg;
        if (fire && (in_command_reg == CMD_START))
        begin
            pen_address_next = setup_address;
            pen_mask_next    = setup_mask;
            error_term_next  = setup_error;
            minor_twice_next = setup_minor;
            major_twice_next = setup_major;
            pixels_left_next = setup_pixels;
            flags_next       = setup_flags;
        end
        else if (emit)
        begin
            pen_address_next = step_address;
            pen_mask_next    = step_mask;
            error_term_next  = step_error;
            pixels_left_next = step_pixels;
            flags_next       = step_flags;
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_base_reg  <= BASE_RESET;
            row_stride_reg  <= STRIDE_RESET;
            in_valid_reg    <= 1'b0;
            in_command_reg  <= CMD_START;
            out_valid_reg   <= 1'b0;
            pen_address_reg <= '0;
            pen_mask_reg    <= '0;
            error_term_reg  <= '0;
            minor_twice_reg <= '0;
            major_twice_reg <= '0;
            pixels_left_reg <= '0;
            flags_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PLANE_BASE: plane_base_reg <= cfg_data;
                    CFG_ROW_STRIDE: row_stride_reg <= cfg_data[STRIDE_BITS-1:0];
                    default:        plane_base_reg <= plane_base_reg;
                endcase
            end

            if (s_axis_tready)
            begin
                in_valid_reg   <= s_axis_tvalid;
                in_command_reg <= command_t'(s_axis_tuser);
            end

            out_valid_reg   <= out_valid_next;
            pen_address_reg <= pen_address_next;
            pen_mask_reg    <= pen_mask_next;
            error_term_reg  <= error_term_next;
            minor_twice_reg <= minor_twice_next;
            major_twice_reg <= major_twice_next;
            pixels_left_reg <= pixels_left_next;
            flags_reg       <= flags_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_data_reg <= s_axis_tdata;
        if (emit)
        begin
            out_address_reg <= pen_address_reg;
            out_mask_reg    <= pen_mask_reg;
            out_last_reg    <= pixels_left_reg == COUNT_BITS'(1);
        end
    end

`ifndef SYNTH
    // The pixel count and the busy flag always agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.busy == (pixels_left_reg != '0))
        else $error("busy flag disagrees with pixel count");

    // While a line is drawn, the pen mask selects exactly one pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.busy |-> $onehot(pen_mask_reg))
        else $error("pen mask is not one-hot");

    // A step on a busy line always produces a pixel write in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_axis_tvalid)
        else $error("step transaction lost its pixel write");

    // The final pixel of a line leaves the stepper idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pixels_left_reg == COUNT_BITS'(1)) |=> !flags_reg.busy)
        else $error("stepper still busy after the final pixel");
`endif

endmodule
